// File: hw/rtl/tmcg_pkg.sv
// shared types and constants for the text mode character generator
// no dependencies; used by tmcg_pixel and the top level
package tmcg_pkg;

    localparam int GLYPH_BYTES  = 2048;
    localparam int GLYPH_AW     = $clog2(GLYPH_BYTES);
    localparam int GLYPH_W      = 8;
    localparam int CODE_W       = 8;
    localparam int TROW_W       = 5;
    localparam int PROW_W       = 3;
    localparam int COL_W        = 6;
    localparam int PIX_W        = 14;
    localparam int HALF_PIX_W   = 7;
    localparam int SCAN_W       = 8;
    localparam int OFFS_W       = 10;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 32;

    localparam logic [OFFS_W-1:0] GROUP_STRIDE = 10'h028;

    // top two code bits select the display class
    localparam logic [1:0] CLASS_INVERSE = 2'b00;
    localparam logic [1:0] CLASS_FLASH   = 2'b01;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              wide_mode;
        logic              flash_phase;
        logic [1:0]        main_class;
        logic [TROW_W-1:0] text_row;
        logic [PROW_W-1:0] pixel_row;
        logic [COL_W-1:0]  column;
    } t_cell;

    typedef struct packed {
        logic              rendered;
        logic [PIX_W-1:0]  pixels;
        logic [SCAN_W-1:0] scanline;
        logic [OFFS_W-1:0] text_offset;
    } t_result;

endpackage

// File: hw/rtl/tmcg_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module tmcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: hw/rtl/tmcg_pixel.sv
// pixel formatting, scanline and text page offset for one cell
// depends on tmcg_pkg
module tmcg_pixel (
    input  tmcg_pkg::t_cell               i_cell,
    input  logic [tmcg_pkg::GLYPH_W-1:0]  i_main_glyph,
    input  logic [tmcg_pkg::GLYPH_W-1:0]  i_aux_glyph,
    output tmcg_pkg::t_result             o_result
);

    logic                              inv;
    logic [tmcg_pkg::PIX_W-1:0]        narrow_pix;
    logic [tmcg_pkg::PIX_W-1:0]        pix;
    logic [tmcg_pkg::OFFS_W-1:0]       row_off;
    logic [tmcg_pkg::OFFS_W-1:0]       group_off;
    logic [tmcg_pkg::OFFS_W-1:0]       offs;

    always_comb begin
        priority if (i_cell.main_class == tmcg_pkg::CLASS_INVERSE) begin
            inv = 1'b1;
        end else if (i_cell.main_class == tmcg_pkg::CLASS_FLASH) begin
            inv = ~i_cell.flash_phase;
        end else begin
            inv = 1'b0;
        end
    end

    // 40 column: bit 6 leftmost, each bit shown twice
    always_comb begin
        for (int k = 0; k < tmcg_pkg::HALF_PIX_W; k++) begin
            narrow_pix[2*k]   = i_main_glyph[tmcg_pkg::HALF_PIX_W-1-k] ^ inv;
            narrow_pix[2*k+1] = i_main_glyph[tmcg_pkg::HALF_PIX_W-1-k] ^ inv;
        end
    end

    assign pix = i_cell.wide_mode
               ? {i_main_glyph[tmcg_pkg::HALF_PIX_W-1:0], i_aux_glyph[tmcg_pkg::HALF_PIX_W-1:0]}
               : narrow_pix;

    assign row_off   = {i_cell.text_row[2:0], 7'b0};
    assign group_off = tmcg_pkg::OFFS_W'(tmcg_pkg::OFFS_W'(i_cell.text_row[4:3])
                                         * tmcg_pkg::GROUP_STRIDE);
    assign offs      = tmcg_pkg::OFFS_W'(row_off + group_off
                                         + tmcg_pkg::OFFS_W'(i_cell.column));

    always_comb begin
        if (i_cell.op == tmcg_pkg::OP_RENDER) begin
            o_result.rendered    = 1'b1;
            o_result.pixels      = pix;
            o_result.scanline    = {i_cell.text_row, i_cell.pixel_row};
            o_result.text_offset = offs;
        end else begin
            o_result = '0;
        end
    end

endmodule

// File: hw/rtl/text_mode_char_generator_top.sv
// top level of the text mode character generator: input stage, glyph ram, output register
// depends on tmcg_pkg, tmcg_ram, tmcg_pixel
//
// Takes one beat per clock while the output side is not stalled and returns one
// beat for each, through the cell stage and the output register. A load beat writes
// one byte of the 2048-byte glyph ram and returns an all-zero beat with tuser low; a
// render beat reads the main and aux glyph bytes through the ram's two
// registered read ports and returns 14 pixels, the scanline and the text page
// offset with tuser high. The glyph ram is not cleared after reset; every
// glyph byte a render reads must have been loaded first.
module text_mode_char_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // glyph_addr, glyph_byte, wide_mode, flash_phase, text_row, pixel_row,
    // column, main_code, aux_code, zero fill
    input  logic [tmcg_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // op
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pixels, scanline, text_offset
    output logic [tmcg_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // rendered
    output logic                              o_m_tuser
);

    logic [tmcg_pkg::GLYPH_AW-1:0]  in_gaddr;
    logic [tmcg_pkg::GLYPH_W-1:0]   in_gbyte;
    logic [tmcg_pkg::PROW_W-1:0]    in_prow;
    logic [tmcg_pkg::CODE_W-1:0]    in_main;
    logic [tmcg_pkg::CODE_W-1:0]    in_aux;
    tmcg_pkg::t_cell                in_cell;
    tmcg_pkg::t_op                  in_op;

    logic                           s_accept;
    logic                           s2_ready;
    logic                           s1_ready;
    logic                           s1_move;

    logic                           r_s1_valid;
    logic                           n_s1_valid;
    tmcg_pkg::t_cell                r_cell;
    logic [tmcg_pkg::GLYPH_W-1:0]   main_glyph;
    logic [tmcg_pkg::GLYPH_W-1:0]   aux_glyph;
    tmcg_pkg::t_result              result;

    logic                           r_out_valid;
    logic                           n_out_valid;
    tmcg_pkg::t_result              r_out;

    assign in_op     = tmcg_pkg::t_op'(i_s_tuser);
    assign in_gaddr  = i_s_tdata[10:0];
    assign in_gbyte  = i_s_tdata[18:11];
    assign in_prow   = i_s_tdata[28:26];
    assign in_main   = i_s_tdata[42:35];
    assign in_aux    = i_s_tdata[50:43];

    always_comb begin
        in_cell.op          = in_op;
        in_cell.wide_mode   = i_s_tdata[19];
        in_cell.flash_phase = i_s_tdata[20];
        in_cell.main_class  = in_main[7:6];
        in_cell.text_row    = i_s_tdata[25:21];
        in_cell.pixel_row   = in_prow;
        in_cell.column      = i_s_tdata[34:29];
    end

    assign s2_ready   = ~r_out_valid | i_m_tready;
    assign s1_ready   = ~r_s1_valid | s2_ready;
    assign o_s_tready = s1_ready;
    assign s_accept   = i_s_tvalid & s1_ready;
    assign s1_move    = r_s1_valid & s2_ready;

    tmcg_ram #(
        .WIDTH (tmcg_pkg::GLYPH_W),
        .DEPTH (tmcg_pkg::GLYPH_BYTES)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_we      (s_accept & (in_op == tmcg_pkg::OP_LOAD)),
        .i_waddr   (in_gaddr),
        .i_wdata   (in_gbyte),
        .i_re      (s_accept & (in_op == tmcg_pkg::OP_RENDER)),
        .i_raddr_a ({in_main, in_prow}),
        .i_raddr_b ({in_aux, in_prow}),
        .o_rdata_a (main_glyph),
        .o_rdata_b (aux_glyph)
    );

    tmcg_pixel u_pixel (
        .i_cell       (r_cell),
        .i_main_glyph (main_glyph),
        .i_aux_glyph  (aux_glyph),
        .o_result     (result)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_ready) begin
            n_s1_valid = i_s_tvalid;
        end
        n_out_valid = r_out_valid;
        if (s2_ready) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cell <= in_cell;
        end
        if (s1_move) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.rendered;
    assign o_m_tdata  = {r_out.text_offset, r_out.scanline, r_out.pixels};

    // a held cell is never dropped while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid)
        else $error("cell stage lost a beat under stall");

    // an empty output register always lets the input side advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty output register");

    // a load result carries nothing but zeros
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("load beat carries nonzero data");

    // an accepted beat reaches the cell stage on the next edge
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid && (r_cell.op == $past(in_op)))
        else $error("accepted beat missing from cell stage");

    // a render result's scanline follows its cell
    a_scanline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_cell.op == tmcg_pkg::OP_RENDER
            |=> r_out.scanline == {$past(r_cell.text_row), $past(r_cell.pixel_row)})
        else $error("scanline does not match cell");

endmodule
